// ===== sv/jse_pkg.sv =====
// Shared constants, types and escape helper functions for the JSON string escape writer.
`default_nettype none

package jse_pkg;

   // Item modes
   localparam logic [2:0] MODE_OPEN    = 3'd0;
   localparam logic [2:0] MODE_STRING  = 3'd1;
   localparam logic [2:0] MODE_CLOSE   = 3'd2;
   localparam logic [2:0] MODE_RAW     = 3'd3;
   localparam logic [2:0] MODE_RESTART = 3'd4;

   // Register map: one register, word addressed at byte address 4*i.
   localparam int          CSR_ADDR_WIDTH     = 3;
   localparam logic [0:0]  CSR_CAPACITY_INDEX = 1'b0;
   localparam logic [15:0] CAPACITY_RESET     = 16'd1024;

   // Characters used by the escaper
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] PRINT_LOW      = 8'd32;
   localparam logic [7:0] PRINT_HIGH     = 8'd126;

   // Expansion of the held item at the current byte position.
   typedef struct packed {
      logic [2:0] length;
      logic [7:0] out_byte;
   } expand_type;

   // Second byte of a two-byte escape, or zero where the byte has none.
   function automatic logic [7:0] escape_second(input logic [7:0] c);
      logic [7:0] second;
      second = 8'h00;
      case (c)
         8'h22:   second = 8'h22;
         8'h5C:   second = 8'h5C;
         8'h08:   second = 8'h62;  // b
         8'h0C:   second = 8'h66;  // f
         8'h0A:   second = 8'h6E;  // n
         8'h0D:   second = 8'h72;  // r
         8'h09:   second = 8'h74;  // t
         default: second = 8'h00;
      endcase
      return second;
   endfunction

   // Lowercase hexadecimal digit for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) begin
         digit = 8'h30 + {4'h0, nibble};
      end else begin
         digit = 8'h57 + {4'h0, nibble};
      end
      return digit;
   endfunction

endpackage

`default_nettype wire

// ===== sv/jse_expand.sv =====
// Escape expansion: sequence length and the byte at a given position for one item.
`default_nettype none

module jse_expand
   import jse_pkg::*;
(
   input  wire logic [2:0] mode,
   input  wire logic [7:0] data_byte,
   input  wire logic [2:0] index,
   output expand_type      expand
);

   logic [7:0] second;
   logic       printable;
   logic [7:0] unicode_byte;

   assign second    = escape_second(data_byte);
   assign printable = (data_byte >= PRINT_LOW) && (data_byte <= PRINT_HIGH);

   // Six-byte form is a backslash, u, two zero digits and the two hex digits.
   always_comb begin
      case (index)
         3'd0:    unicode_byte = CHAR_BACKSLASH;
         3'd1:    unicode_byte = CHAR_U;
         3'd2:    unicode_byte = CHAR_ZERO;
         3'd3:    unicode_byte = CHAR_ZERO;
         3'd4:    unicode_byte = hex_digit(data_byte[7:4]);
         default: unicode_byte = hex_digit(data_byte[3:0]);
      endcase
   end

   // Select the sequence for the mode and, for string bytes, the escape class.
   always_comb begin
      case (mode)
         MODE_OPEN, MODE_CLOSE: begin
            expand.length   = 3'd1;
            expand.out_byte = CHAR_QUOTE;
         end
         MODE_RAW: begin
            expand.length   = 3'd1;
            expand.out_byte = data_byte;
         end
         MODE_STRING: begin
            if (second != 8'h00) begin
               expand.length   = 3'd2;
               expand.out_byte = (index == 3'd0) ? CHAR_BACKSLASH : second;
            end else if (printable) begin
               expand.length   = 3'd1;
               expand.out_byte = data_byte;
            end else begin
               expand.length   = 3'd6;
               expand.out_byte = unicode_byte;
            end
         end
         default: begin
            // Restart and unused modes produce no bytes.
            expand.length   = 3'd0;
            expand.out_byte = 8'h00;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/json_string_escape_writer.sv =====
// Top level of the JSON string escape writer: item register, fill counter and result register.
`default_nettype none

// Each accepted item is held in an item register and expanded into its output text one
// byte per cycle while the result channel does not stall, into a single result
// register: quotes and raw bytes give one byte, a string byte gives one, two or six
// bytes, and a restart or unused mode gives none. The next item is taken in the same
// cycle as the last byte of the current one is loaded, or while a restart or an unused
// mode is held, so the result channel can carry one byte every cycle while it is not
// stalled. The rate is set by the single result register, which moves one byte per
// transfer.
// The fill count is advanced as each byte is produced; bytes beyond the capacity register
// are still delivered with kept low. Capacity is written through the APB-style port at
// byte address 0 and should only be changed while the block is idle.

module json_string_escape_writer
   import jse_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Input channel
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [2:0]                req_mode,
   input  wire logic [7:0]                req_data_byte,
   // Result channel
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [7:0]                rsp_out_byte,
   output      logic                      rsp_kept,
   output      logic [15:0]               rsp_fill_after,
   output      logic                      rsp_last,
   // Configuration port
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output      logic [31:0]               csr_prdata,
   output      logic                      csr_pready
);

   logic        item_valid_ff, item_valid_in;
   logic [2:0]  item_mode_ff;
   logic [7:0]  item_data_ff;
   logic [2:0]  index_ff, index_in;
   logic [15:0] fill_ff, fill_in;
   logic [15:0] capacity_ff, capacity_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_kept_ff;
   logic [15:0] out_fill_ff;
   logic        out_last_ff;

   expand_type  expand;
   logic        out_free;
   logic        emit;
   logic        item_last;
   logic        item_done;
   logic        accept;
   logic        has_room;
   logic        csr_write;

   // Configuration register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_CAPACITY_INDEX);
   assign capacity_in = csr_write ? csr_pwdata[15:0] : capacity_ff;

   always_comb begin
      if (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_CAPACITY_INDEX) begin
         csr_prdata = {16'h0000, capacity_ff};
      end else begin
         csr_prdata = 32'h0000_0000;
      end
   end

   // Expansion of the held item at the current byte position.
   jse_expand u_expand (
      .mode      (item_mode_ff),
      .data_byte (item_data_ff),
      .index     (index_ff),
      .expand    (expand)
   );

   // A byte is produced for a held item with bytes to give whenever the result register is empty or being emptied.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit      = item_valid_ff && (expand.length != 3'd0) && out_free;
   assign item_last = (index_ff == 3'(expand.length - 3'd1));
   assign item_done = item_valid_ff && ((expand.length == 3'd0) || (emit && item_last));
   assign req_ready = !item_valid_ff || item_done;
   assign accept    = req_valid && req_ready;

   // Item register control
   always_comb begin
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_comb begin
      if (accept) begin
         index_in = 3'd0;
      end else if (emit) begin
         index_in = index_ff + 3'd1;
      end else begin
         index_in = index_ff;
      end
   end

   // Fill counter: counts kept bytes, cleared by a restart.
   assign has_room = (fill_ff < capacity_ff);

   always_comb begin
      if (item_valid_ff && (item_mode_ff == MODE_RESTART)) begin
         fill_in = 16'd0;
      end else if (emit && has_room) begin
         fill_in = fill_ff + 16'd1;
      end else begin
         fill_in = fill_ff;
      end
   end

   // Result register occupancy
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         index_ff      <= 3'd0;
         fill_ff       <= 16'd0;
         capacity_ff   <= CAPACITY_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         index_ff      <= index_in;
         fill_ff       <= fill_in;
         capacity_ff   <= capacity_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_mode_ff <= req_mode;
         item_data_ff <= req_data_byte;
      end
      if (emit) begin
         out_byte_ff <= expand.out_byte;
         out_kept_ff <= has_room;
         out_fill_ff <= fill_in;
         out_last_ff <= item_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_kept       = out_kept_ff;
   assign rsp_fill_after = out_fill_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/jse_checker.sv =====
// Port-level checker for the JSON string escape writer and its bind statement.
`default_nettype none

module jse_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_kept,
   input wire logic [15:0] rsp_fill_after,
   input wire logic        rsp_last
);

   logic rsp_transfer;

   assign rsp_transfer = rsp_valid && rsp_ready;

   // A stalled result holds its byte and flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_kept) && $stable(rsp_fill_after) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid directly after reset");

   // A kept byte always leaves at least one byte in the buffer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kept |-> rsp_fill_after != 16'd0)
      else $error("kept byte with empty buffer");

   // A dropped byte followed at once by the next byte of the same item leaves the fill unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_transfer && !rsp_kept && !rsp_last) ##1 rsp_transfer
         |-> !rsp_kept && (rsp_fill_after == $past(rsp_fill_after)))
      else $error("fill moved after a dropped byte");

   // Back-to-back kept bytes of one item advance the fill by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_transfer && rsp_kept && !rsp_last) ##1 (rsp_transfer && rsp_kept)
         |-> rsp_fill_after == $past(rsp_fill_after) + 16'd1)
      else $error("fill did not advance by one");

endmodule

bind json_string_escape_writer jse_checker u_jse_checker (.*);

`default_nettype wire

// ===== tb/json_string_escape_writer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string escape writer: random and directed text items.
module json_string_escape_writer_test;
   import jse_pkg::*;

   localparam logic [2:0] MODE_SPARE_FIRST = MODE_RESTART + 3'd1;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] ASCII_ZERO     = "0";
   localparam logic [7:0] ASCII_LOWER_A  = "a";
   localparam logic [7:0] NO_PAIR        = 8'h00;
   localparam logic [7:0] JSON_MARKS [0:5] = '{"[", "]", "{", "}", ",", ":"};

   localparam int IDLE_MAX      = 13;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data_byte;
   } text_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        kept;
      logic [15:0] fill_after;
      logic        last;
   } text_byte_type;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_mode      = '0;
   logic [7:0]                req_data_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   logic [7:0]                rsp_out_byte;
   logic                      rsp_kept;
   logic [15:0]               rsp_fill_after;
   logic                      rsp_last;
   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr     = '0;
   logic [31:0]               csr_pwdata    = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // Predictor state: its own copy of the capacity register and of the fill counter.
   logic [15:0] capacity_copy = CAPACITY_RESET;
   logic [15:0] buffer_fill   = '0;

   text_item_type pending_items[$];
   text_byte_type expected_text[$];

   int error_count    = 0;
   int items_taken    = 0;
   int bytes_checked  = 0;
   int bytes_dropped  = 0;
   int escapes_seen   = 0;
   int restarts_taken = 0;

   // Handshake bookkeeping shared between the sampling and the driving processes.
   bit send_gaps   = 1'b1;
   bit recv_stalls = 1'b1;
   bit offering    = 1'b0;
   bit item_taken  = 1'b0;
   bit byte_taken  = 1'b0;
   int gap_left    = 0;
   int stall_left  = 0;
   int hold_left   = 0;

   always #5 clock = ~clock;

   json_string_escape_writer dut (.*);

   // Lowercase hexadecimal character for one nibble.
   function automatic logic [7:0] nibble_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return ASCII_ZERO + 8'(nibble);
      end
      return ASCII_LOWER_A + 8'(nibble) - 8'd10;
   endfunction

   // Appends one produced byte to the expected text, counting it only while there is room.
   function automatic void store_byte(input logic [7:0] value, input logic is_last);
      text_byte_type entry;
      entry.out_byte = value;
      entry.kept     = (buffer_fill < capacity_copy);
      if (entry.kept) begin
         buffer_fill = buffer_fill + 16'd1;
      end else begin
         bytes_dropped++;
      end
      entry.fill_after = buffer_fill;
      entry.last       = is_last;
      expected_text.push_back(entry);
   endfunction

   // Works out the output text of one accepted item and queues it as expected bytes.
   function automatic void predict_text(input logic [2:0] mode, input logic [7:0] data);
      logic [7:0] text[$];
      logic [7:0] pair;
      pair = NO_PAIR;
      case (mode)
         MODE_OPEN, MODE_CLOSE: text.push_back(CHAR_QUOTE);
         MODE_RAW: text.push_back(data);
         MODE_RESTART: begin
            buffer_fill = '0;
            restarts_taken++;
         end
         MODE_STRING: begin
            case (data)
               CHAR_QUOTE, CHAR_BACKSLASH: pair = data;
               CHAR_BACKSPACE: pair = "b";
               CHAR_FORM_FEED: pair = "f";
               CHAR_NEWLINE:   pair = "n";
               CHAR_RETURN:    pair = "r";
               CHAR_TAB:       pair = "t";
               default:        pair = NO_PAIR;
            endcase
            if (pair != NO_PAIR) begin
               text.push_back(CHAR_BACKSLASH);
               text.push_back(pair);
               escapes_seen++;
            end else if (data >= PRINT_LOW && data <= PRINT_HIGH) begin
               text.push_back(data);
            end else begin
               // Control and high bytes become a six-byte unicode escape.
               text.push_back(CHAR_BACKSLASH);
               text.push_back(CHAR_U);
               text.push_back(CHAR_ZERO);
               text.push_back(CHAR_ZERO);
               text.push_back(nibble_char(data[7:4]));
               text.push_back(nibble_char(data[3:0]));
               escapes_seen++;
            end
         end
         default: ;
      endcase
      foreach (text[i]) begin
         store_byte(text[i], i == text.size() - 1);
      end
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Sample both channels at the rising edge: predict on item transfers, check result transfers.
   always @(posedge clock) begin : transfer_check
      text_byte_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_text(req_mode, req_data_byte);
            items_taken++;
            item_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            byte_taken = 1'b1;
            bytes_checked++;
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected result byte, expected none, actual %h kept %b fill %0d",
                        $time, rsp_out_byte, rsp_kept, rsp_fill_after);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               compare_field("out_byte", 16'(want.out_byte), 16'(rsp_out_byte));
               compare_field("kept", 16'(want.kept), 16'(rsp_kept));
               compare_field("fill_after", want.fill_after, rsp_fill_after);
               compare_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
      end
   end

   // Item driver: offers the next pending item after a random gap, holding it until its transfer.
   always @(negedge clock) begin : item_driver
      text_item_type next_item;
      if (!reset) begin
         if (item_taken) begin
            item_taken = 1'b0;
            offering   = 1'b0;
            gap_left   = send_gaps ? int'($urandom_range(0, IDLE_MAX)) : 0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_mode      <= next_item.mode;
               req_data_byte <= next_item.data_byte;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // Result receiver: random stalls after each transfer, and a long hold when one is requested.
   always @(negedge clock) begin : byte_receiver
      if (!reset) begin
         if (byte_taken) begin
            byte_taken = 1'b0;
            stall_left = recv_stalls ? int'($urandom_range(0, IDLE_MAX)) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void queue_item(input logic [2:0] mode, input logic [7:0] data);
      text_item_type entry;
      entry.mode      = mode;
      entry.data_byte = data;
      pending_items.push_back(entry);
   endfunction

   // String content drawn from printable, escaped, control and high byte classes.
   function automatic logic [7:0] random_string_byte();
      logic [7:0] pick;
      case ($urandom_range(0, 4))
         0: pick = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
         1: begin
            case ($urandom_range(0, 6))
               0:       pick = CHAR_QUOTE;
               1:       pick = CHAR_BACKSLASH;
               2:       pick = CHAR_BACKSPACE;
               3:       pick = CHAR_FORM_FEED;
               4:       pick = CHAR_NEWLINE;
               5:       pick = CHAR_RETURN;
               default: pick = CHAR_TAB;
            endcase
         end
         2: pick = 8'($urandom_range(0, PRINT_LOW - 1));
         3: pick = 8'($urandom_range(PRINT_HIGH + 1, 255));
         default: pick = 8'($urandom);
      endcase
      return pick;
   endfunction

   function automatic logic [7:0] random_raw_byte();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom);
      end
      return JSON_MARKS[$urandom_range(0, 5)];
   endfunction

   // Mostly well-formed quoted strings with random content, the rest loose items of any mode.
   task automatic queue_random(input int count);
      int         queued;
      int         length;
      logic [2:0] mode;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_item(MODE_RESTART, 8'($urandom));
               queued++;
            end
            queue_item(MODE_OPEN, 8'($urandom));
            length = $urandom_range(0, 8);
            repeat (length) queue_item(MODE_STRING, random_string_byte());
            queue_item(MODE_CLOSE, 8'($urandom));
            queued += length + 2;
            if ($urandom_range(0, 1) == 1) begin
               queue_item(MODE_RAW, random_raw_byte());
               queued++;
            end
         end else begin
            mode = 3'($urandom_range(0, 7));
            queue_item(mode, 8'($urandom));
            if (mode <= MODE_RESTART) begin
               queued++;
            end
         end
      end
   endtask

   // Waits until every item has gone and every expected byte has arrived, then lets it settle.
   task automatic wait_idle();
      while (pending_items.size() > 0 || offering || hold_left > 0 || expected_text.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the capacity register, then reads it back within the same selection.
   task automatic write_capacity(input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_CAPACITY_INDEX, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      capacity_copy = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0000, value}) begin
         $display("%0t: capacity read-back mismatch, expected %0d, actual %0d",
                  $time, value, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : run_phases
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every mode and every escape class at the reset capacity.
      queue_item(MODE_OPEN, 8'hFF);
      queue_item(MODE_STRING, CHAR_QUOTE);
      queue_item(MODE_STRING, CHAR_BACKSLASH);
      queue_item(MODE_STRING, CHAR_BACKSPACE);
      queue_item(MODE_STRING, CHAR_FORM_FEED);
      queue_item(MODE_STRING, CHAR_NEWLINE);
      queue_item(MODE_STRING, CHAR_RETURN);
      queue_item(MODE_STRING, CHAR_TAB);
      queue_item(MODE_STRING, 8'h00);
      queue_item(MODE_STRING, PRINT_LOW - 8'd1);
      queue_item(MODE_STRING, PRINT_LOW);
      queue_item(MODE_STRING, PRINT_HIGH);
      queue_item(MODE_STRING, PRINT_HIGH + 8'd1);
      queue_item(MODE_STRING, 8'hFF);
      queue_item(MODE_STRING, "/");
      queue_item(MODE_STRING, "A");
      queue_item(MODE_CLOSE, 8'h00);
      queue_item(MODE_RAW, 8'h00);
      queue_item(MODE_RAW, 8'hFF);
      queue_item(MODE_RAW, ",");
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
         queue_item(3'(m), 8'($urandom));
      end
      queue_item(MODE_RESTART, 8'h55);
      queue_item(MODE_OPEN, 8'hAA);
      wait_idle();

      // Zero capacity drops everything, even straight after a restart.
      write_capacity(16'd0);
      queue_item(MODE_STRING, 8'h01);
      queue_item(MODE_RAW, ":");
      queue_item(MODE_RESTART, 8'h00);
      queue_item(MODE_OPEN, 8'h00);
      queue_item(MODE_CLOSE, 8'h00);
      queue_random(20);
      wait_idle();

      // Smallest capacity, with both sides running flat out.
      write_capacity(16'd1);
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      queue_random(60);
      wait_idle();

      // Largest capacity; the receiver holds off while the sender keeps offering.
      write_capacity(16'hFFFF);
      recv_stalls = 1'b1;
      hold_left   = HOLD_CYCLES;
      queue_random(80);
      wait_idle();

      // Capacity lowered below the current fill: drops until the next restart.
      write_capacity(16'd3);
      send_gaps = 1'b1;
      queue_random(80);
      wait_idle();

      // A unicode escape cut off partway by the capacity.
      write_capacity(16'd9);
      queue_item(MODE_RESTART, 8'h00);
      queue_item(MODE_OPEN, 8'h00);
      queue_item(MODE_STRING, 8'h01);
      queue_item(MODE_STRING, 8'h02);
      queue_item(MODE_STRING, CHAR_QUOTE);
      queue_item(MODE_CLOSE, 8'h00);
      queue_item(MODE_RESTART, 8'h00);
      queue_random(80);
      wait_idle();

      write_capacity(16'($urandom_range(10, 300)));
      send_gaps = 1'b0;
      queue_random(50);
      wait_idle();

      write_capacity(CAPACITY_RESET);
      send_gaps = 1'b1;
      queue_random(50);
      wait_idle();

      $display("Run covered %0d items, %0d result bytes (%0d dropped past capacity), %0d escapes",
               items_taken, bytes_checked, bytes_dropped, escapes_seen);
      $display("and %0d restarts, over capacities from zero to full scale with a long stall.",
               restarts_taken);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #(5_000_000);
      $display("%0t: timed out with %0d results outstanding", $time, expected_text.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
